/* src/set_assoc_cache_bit_plru_core_defines.svh */
// Assertion macros for the bit-PLRU cache tag store core.
// Used by set_assoc_cache_bit_plru_core.sv; expects clk and arst_n in scope.
`ifndef SET_ASSOC_CACHE_BIT_PLRU_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_BIT_PLRU_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SACBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SACBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sacbp_pkg.sv */
// Package for the bit-PLRU cache tag store core: FSM states and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package sacbp_pkg;

	// Fixed field widths
	localparam int ADDR_W    = 64;
	localparam int CNT_W     = 32;
	localparam int WAY_OUT_W = 3;

	// Saturation value of the access and miss counters
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_CMP,
		S_WB
	} state_t;

endpackage

/* src/set_assoc_cache_bit_plru_core.sv */
// Tag store of a set-associative cache with bit-PLRU replacement; uses sacbp_pkg.
// Takes one word at a time: busy stays high through the set-memory read, tag compare
// and write-back of one set row, then done pulses. For a set count that is not a power
// of two, the set index is first worked out as a restoring remainder of the address
// above the offset bits, one nibble a step. After reset, busy stays high while the
// valid/used memory is cleared. Hit and way are held until the next write-back.
`timescale 1ns / 1ps

`include "set_assoc_cache_bit_plru_core_defines.svh"

module set_assoc_cache_bit_plru_core
	import sacbp_pkg::*;
#(
	parameter int NUM_SETS    = 512,
	parameter int WAYS        = 8,
	parameter int BLOCK_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  logic [ADDR_W-1:0]    address,
	output logic                 done,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way,
	output logic [CNT_W-1:0]     read_misses,
	output logic [CNT_W-1:0]     write_misses,
	output logic [CNT_W-1:0]     read_accesses,
	output logic [CNT_W-1:0]     write_accesses
);

	// Address split
	localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IDX_BITS = $clog2(NUM_SETS + 1) - 1;
	localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
	localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam bit NEED_DIV = ((NUM_SETS & (NUM_SETS - 1)) != 0);

	state_t state_q, state_d;

	logic                   accept;
	logic                   op_q;
	logic [TAG_W-1:0]       tag_q;
	logic [SET_W-1:0]       set_q;
	logic [SET_W-1:0]       set_acc;
	logic [SET_W-1:0]       set_div;
	logic                   div_last;
	logic [SET_W-1:0]       clr_q;

	// Set memories and their registered read data
	logic [WAYS*TAG_W-1:0]  tag_mem [NUM_SETS];
	logic [2*WAYS-1:0]      meta_mem [NUM_SETS];
	logic [WAYS*TAG_W-1:0]  tag_rd_q;
	logic [2*WAYS-1:0]      meta_rd_q;

	logic                   rd_en;
	logic                   tag_we;
	logic                   meta_we;
	logic [SET_W-1:0]       meta_waddr;
	logic [2*WAYS-1:0]      meta_wdata;
	logic [WAYS*TAG_W-1:0]  tag_wdata;

	logic [WAYS-1:0]        valid_rd;
	logic [WAYS-1:0]        used_rd;
	logic [WAYS-1:0]        match_c;
	logic [WAYS-1:0]        match_q;
	logic                   hit_c;
	logic [WAY_W-1:0]       hit_way;
	logic [WAY_W-1:0]       victim;
	logic [WAY_W-1:0]       sel_way;
	logic [WAYS-1:0]        sel_oh;
	logic [WAYS-1:0]        used_or;
	logic [WAYS-1:0]        used_new;
	logic [WAYS-1:0]        valid_new;

	logic                   done_q;
	logic                   hit_q;
	logic [WAY_OUT_W-1:0]   way_q;
	logic [CNT_W-1:0]       rd_miss_q;
	logic [CNT_W-1:0]       wr_miss_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic [CNT_W-1:0]       wr_cnt_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Set index: plain bit field, or a remainder worked out four bits a cycle
	generate
		if (!NEED_DIV) begin : g_set_field
			if (NUM_SETS == 1) begin : g_one_set
				assign set_acc = '0;
			end else begin : g_many_sets
				assign set_acc = address[OFF_BITS +: SET_W];
			end
			assign set_div  = '0;
			assign div_last = 1'b1;
		end else begin : g_set_rem
			localparam int SHW   = ADDR_W - OFF_BITS;
			localparam int NDIG  = (SHW + 3) / 4;
			localparam int PADW  = NDIG * 4;
			localparam int DCW   = (NDIG > 1) ? $clog2(NDIG) : 1;

			logic [PADW-1:0]  dig_q;
			logic [SET_W-1:0] rem_q;
			logic [DCW-1:0]   dcnt_q;
			logic [SET_W-1:0] rem_c;
			logic [SET_W:0]   ext;

			// One nibble of restoring remainder steps
			always_comb begin
				rem_c = rem_q;
				ext   = '0;
				for (int j = 0; j < 4; j++) begin
					ext = {rem_c, dig_q[PADW-1-j]};
					if (ext >= (SET_W+1)'(NUM_SETS)) begin
						ext = ext - (SET_W+1)'(NUM_SETS);
					end
					rem_c = ext[SET_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rem_q  <= '0;
					dcnt_q <= '0;
				end else if (accept) begin
					rem_q  <= '0;
					dcnt_q <= DCW'(NDIG - 1);
				end else if (state_q == S_DIV) begin
					rem_q  <= rem_c;
					dcnt_q <= dcnt_q - 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (accept) begin
					dig_q <= PADW'(address[ADDR_W-1:OFF_BITS]);
				end else if (state_q == S_DIV) begin
					dig_q <= dig_q << 4;
				end
			end

			assign set_acc  = '0;
			assign set_div  = rem_c;
			assign div_last = (dcnt_q == '0);
		end
	endgenerate

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Next state and memory strobes
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		tag_we  = 1'b0;
		meta_we = 1'b0;
		unique case (state_q)
			S_CLR: begin
				meta_we = 1'b1;
				if (clr_q == SET_W'(NUM_SETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = NEED_DIV ? S_DIV : S_READ;
				end
			end
			S_DIV: begin
				if (div_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_WB;
			end
			S_WB: begin
				tag_we  = !hit_c;
				meta_we = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Captured access word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			tag_q <= address[ADDR_W-1 -: TAG_W];
			set_q <= set_acc;
		end else if (state_q == S_DIV && div_last) begin
			set_q <= set_div;
		end
	end

	// Set memories: one read and one write port each
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_q  <= tag_mem[set_q];
			meta_rd_q <= meta_mem[set_q];
		end
		if (tag_we) begin
			tag_mem[set_q] <= tag_wdata;
		end
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
	end

	assign valid_rd = meta_rd_q[2*WAYS-1:WAYS];
	assign used_rd  = meta_rd_q[WAYS-1:0];

	// Tag compare across the ways
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			match_c[i] = valid_rd[i] && (tag_rd_q[i*TAG_W +: TAG_W] == tag_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			match_q <= match_c;
		end
	end

	// Lowest hitting way and lowest way with a clear used bit
	always_comb begin
		hit_way = '0;
		victim  = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_way = WAY_W'(i);
			end
			if (!used_rd[i]) begin
				victim = WAY_W'(i);
			end
		end
	end

	assign hit_c   = |match_q;
	assign sel_way = hit_c ? hit_way : victim;

	// Used and valid update, tag row with the victim lane refilled
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			sel_oh[i] = (sel_way == WAY_W'(i));
			tag_wdata[i*TAG_W +: TAG_W] = sel_oh[i] ? tag_q : tag_rd_q[i*TAG_W +: TAG_W];
		end
		used_or   = used_rd | sel_oh;
		used_new  = (&used_or) ? sel_oh : used_or;
		valid_new = valid_rd | sel_oh;
	end

	assign meta_waddr = (state_q == S_CLR) ? clr_q : set_q;
	assign meta_wdata = (state_q == S_CLR) ? '0 : {valid_new, used_new};

	// Result word and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			rd_miss_q <= '0;
			wr_miss_q <= '0;
			rd_cnt_q  <= '0;
			wr_cnt_q  <= '0;
		end else begin
			done_q <= (state_q == S_WB);
			if (state_q == S_WB) begin
				if (op_q == OP_WRITE) begin
					if (wr_cnt_q != COUNT_MAX) wr_cnt_q <= wr_cnt_q + 1'b1;
					if (!hit_c && wr_miss_q != COUNT_MAX) wr_miss_q <= wr_miss_q + 1'b1;
				end else begin
					if (rd_cnt_q != COUNT_MAX) rd_cnt_q <= rd_cnt_q + 1'b1;
					if (!hit_c && rd_miss_q != COUNT_MAX) rd_miss_q <= rd_miss_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WB) begin
			hit_q <= hit_c;
			way_q <= WAY_OUT_W'(sel_way);
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign way            = way_q;
	assign read_misses    = rd_miss_q;
	assign write_misses   = wr_miss_q;
	assign read_accesses  = rd_cnt_q;
	assign write_accesses = wr_cnt_q;

	// Checks
	`SACBP_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result strobe outside idle")
	`SACBP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accepted word")
	`SACBP_ASSERT_NEXT(a_cnt_hold, state_q != S_WB,
		$stable({rd_miss_q, wr_miss_q, rd_cnt_q, wr_cnt_q}), "counter moved outside write-back")
	`SACBP_ASSERT_NOW(a_miss_le_acc, 1'b1,
		(rd_miss_q <= rd_cnt_q) && (wr_miss_q <= wr_cnt_q), "miss count above access count")

endmodule
